[src/cqfs_pkg.sv]
// ----------------------------------------------------------------------------
// cqfs_pkg
// Shared constants and types for the first-seen color labeler.
// ----------------------------------------------------------------------------
package cqfs_pkg;

  // channel and result field widths
  localparam int CHANNEL_BITS  = 8;
  localparam int KEPT_BITS_DEF = 4;
  localparam int LABEL_W       = 12;
  localparam int COUNT_W       = 13;
  localparam int LABEL_MAX     = 4095;
  localparam int COUNT_MAX     = 8191;

  // image tag kept next to every table entry, zero marks a cleared entry
  localparam int EPOCH_BITS = 8;
  localparam logic [EPOCH_BITS-1:0] EPOCH_NONE = '0;
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = '1;

  // table geometry at the default setting
  localparam int CODE_BITS_DEF = 3 * KEPT_BITS_DEF;
  localparam int WORD_W_DEF    = EPOCH_BITS + CODE_BITS_DEF;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

endpackage

[src/cqfs_table.sv]
// ----------------------------------------------------------------------------
// cqfs_table
// Code-to-entry memory, one read and one write port, registered read data,
// with the most recent write forwarded over a same-edge read of its entry.
// ----------------------------------------------------------------------------
module cqfs_table
  import cqfs_pkg::*;
#(
  parameter int ADDR_W = CODE_BITS_DEF,
  parameter int DATA_W = WORD_W_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [ADDR_W-1:0] rd_addr_q;

  logic              last_valid;
  logic [ADDR_W-1:0] last_addr;
  logic [DATA_W-1:0] last_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // remember the latest write, a read on the same edge misses it
  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
    end else if (wr_en) begin
      last_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_addr <= wr_addr;
      last_data <= wr_data;
    end
  end

  assign rd_data = (last_valid && last_addr == rd_addr_q) ? last_data : rd_q;

endmodule

[src/color_quantize_first_seen_labeler.sv]
// ----------------------------------------------------------------------------
// color_quantize_first_seen_labeler
// Quantizes blue, green, red pixels to a color code and hands out dense
// labels in first-seen order per image.
// ----------------------------------------------------------------------------
// One pixel per clock in steady state while m_tready is high; each result passes
// through the lookup stage and the result register. The loop that sets the rate
// is the table read, hit check and write back through a single-port-read memory,
// closed by forwarding of the last write. Each table entry carries an 8-bit
// image tag, so starting an image costs no time. After reset, and when the tag
// runs out (once in every 255 images), the block sweeps all
// 2^(3*KEPT_BITS_PER_CHANNEL) table entries (4096 at the default) with s_tready
// low; the pixel that opens the image waits at the input during that sweep.
module color_quantize_first_seen_labeler
  import cqfs_pkg::*;
#(
  parameter int KEPT_BITS_PER_CHANNEL = KEPT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // blue [7:0], green [15:8], red [23:16]
  input  logic        s_tuser,   // first_of_image
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // label [11:0], segments_so_far [24:12], zero
);

  localparam int K         = KEPT_BITS_PER_CHANNEL;
  localparam int CODE_BITS = 3 * K;
  localparam int CNT_W     = CODE_BITS + 1;
  localparam int WORD_W    = EPOCH_BITS + CODE_BITS;
  localparam int SAT_W     = CODE_BITS + COUNT_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(1) << CODE_BITS;

  state_t state, state_next;

  logic [CODE_BITS-1:0]  clr_addr;
  logic [EPOCH_BITS-1:0] epoch;
  logic [EPOCH_BITS-1:0] epoch_next;
  logic [CNT_W-1:0]      cnt;

  logic                  s1_valid;
  logic [CODE_BITS-1:0]  s1_code;
  logic                  s1_first;
  logic [EPOCH_BITS-1:0] s1_epoch;

  logic                  out_valid;
  logic [LABEL_W-1:0]    out_label;
  logic [COUNT_W-1:0]    out_seg;

  logic [CODE_BITS-1:0]  in_code;
  logic [EPOCH_BITS-1:0] in_epoch;
  logic                  in_accept;
  logic                  wrap_hold;
  logic                  wrap_start;
  logic                  s1_adv;
  logic                  clearing;

  logic [WORD_W-1:0]     rd_word;
  logic                  hit;
  logic [CNT_W-1:0]      base;
  logic [CNT_W-1:0]      cnt_new;
  logic [CODE_BITS-1:0]  lab;
  logic [SAT_W-1:0]      lab_ext;
  logic [SAT_W-1:0]      cnt_ext;

  logic                  wr_en;
  logic [CODE_BITS-1:0]  wr_addr;
  logic [WORD_W-1:0]     wr_data;

  // quantized code: blue lowest, red highest
  assign in_code = {s_tdata[23 -: K], s_tdata[15 -: K], s_tdata[7 -: K]};

  assign in_epoch  = s_tuser ? epoch + EPOCH_BITS'(1) : epoch;
  assign wrap_hold = s_tuser && (epoch == EPOCH_LAST);

  assign s1_adv    = s1_valid && (!out_valid || m_tready);
  assign s_tready  = (state == ST_RUN) && !wrap_hold && (!s1_valid || s1_adv);
  assign in_accept = s_tvalid && s_tready;

  // tag exhausted: sweep once the lookup stage holds nothing
  assign wrap_start = s_tvalid && wrap_hold && !s1_valid;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (wrap_start) begin
          state_next = ST_CLEAR;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   clearing = 1'b0;
      default:  clearing = 1'b1;
    endcase
  end

  always_comb begin
    epoch_next = epoch;
    if (state == ST_RUN && wrap_start) begin
      epoch_next = EPOCH_NONE;
    end else if (in_accept) begin
      epoch_next = in_epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      epoch    <= EPOCH_NONE + EPOCH_BITS'(1);
    end else begin
      state <= state_next;
      epoch <= epoch_next;
      if (clearing) begin
        clr_addr <= clr_addr + CODE_BITS'(1);
      end else begin
        clr_addr <= '0;
      end
    end
  end

  cqfs_table #(
    .ADDR_W (CODE_BITS),
    .DATA_W (WORD_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (in_code),
    .rd_data (rd_word),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // lookup stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_code  <= in_code;
      s1_first <= s_tuser;
      s1_epoch <= in_epoch;
    end
  end

  assign hit  = rd_word[WORD_W-1 -: EPOCH_BITS] == s1_epoch;
  assign base = s1_first ? '0 : cnt;
  assign lab  = hit ? rd_word[CODE_BITS-1:0] : base[CODE_BITS-1:0];

  always_comb begin
    cnt_new = base;
    if (!hit && base < DEPTH_CNT) begin
      cnt_new = base + CNT_W'(1);
    end
  end

  // sweep writes cleared entries, otherwise a new code is written back
  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = {EPOCH_NONE, {CODE_BITS{1'b0}}};
    end else begin
      wr_en   = s1_adv && !hit;
      wr_addr = s1_code;
      wr_data = {s1_epoch, lab};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (s1_adv) begin
      cnt <= cnt_new;
    end
  end

  // result register
  assign lab_ext = SAT_W'(lab);
  assign cnt_ext = SAT_W'(cnt_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_label <= (lab_ext > SAT_W'(LABEL_MAX)) ? LABEL_W'(LABEL_MAX) : LABEL_W'(lab_ext);
      out_seg   <= (cnt_ext > SAT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : COUNT_W'(cnt_ext);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_seg, out_label};

  a_no_accept_in_sweep : assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input transfer during table sweep");

  a_item_tag_live : assert property (@(posedge clk) disable iff (rst)
    in_accept |-> in_epoch != EPOCH_NONE)
    else $error("pixel tagged with the cleared-entry tag");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    cnt <= DEPTH_CNT)
    else $error("label counter beyond table depth");

  a_result_nonzero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_seg != '0)
    else $error("result with no segment counted");

  a_sweep_empty_pipe : assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && state_next == ST_CLEAR) |-> !s1_valid)
    else $error("sweep started with a lookup in flight");

endmodule
